/* src/assert_macros.svh */
// Assertion helpers used by the checker in src/a2i_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is applied.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, ignored while reset is applied.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* src/a2i_pkg.sv */
package a2i_pkg;

  // Channel and configuration widths.
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned ROW_W      = 12;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // Reset values and limits.
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 13'd480;
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MAX_HEIGHT    = 4096;

  // BT.601 limited-range coefficients.
  localparam int unsigned Y_R = 66;
  localparam int unsigned Y_G = 129;
  localparam int unsigned Y_B = 25;
  localparam int unsigned Y_OFS = 'h1080;
  localparam int unsigned U_R = 38;
  localparam int unsigned U_G = 74;
  localparam int unsigned U_B = 112;
  localparam int unsigned V_R = 112;
  localparam int unsigned V_G = 94;
  localparam int unsigned V_B = 18;
  localparam int unsigned C_OFS = 'h8080;

  // One pixel as stored in the row buffer.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // How the chroma block of a pixel is formed.
  typedef enum logic [2:0] {
    BLK_NONE = 3'd0,
    BLK_AVG4 = 3'd1,
    BLK_VERT = 3'd2,
    BLK_HORZ = 3'd3,
    BLK_PASS = 3'd4
  } blk_mode_t;

endpackage

/* src/a2i_stream_if.sv */
// Pixel input channel: one RGB pixel per transfer.
interface argb_in_if;
  import a2i_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Result channel: luma of every pixel, chroma on completed blocks.
interface i420_out_if;
  import a2i_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] luma;
  logic            chroma_valid;
  logic [CH_W-1:0] chroma_u;
  logic [CH_W-1:0] chroma_v;
  logic            frame_end;

  modport source (output valid, output luma, output chroma_valid, output chroma_u,
                  output chroma_v, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input chroma_u,
                  input chroma_v, input frame_end, output ready);
endinterface

/* src/argb_to_i420_converter_top.sv */
// RGB to BT.601 4:2:0 converter. Pixels arrive in raster order and each one
// produces one result, which passes the stage registers and is offered from the output register;
// a new pixel is taken every clock cycle as long as the result side keeps up. Every result carries
// the pixel's luma; on the second row of each row pair the odd columns (and
// the last column of an odd width) also carry U and V of the 2x2 block, and
// on an odd final row they come from horizontal pairs. The even row of each
// pair is kept in a single-port row buffer of MAX_WIDTH pixels, written on
// even rows and read one entry per pixel on odd rows, which sets the rate of
// one pixel per cycle. The buffer is not cleared after reset and holds valid
// data only once a row has been written; the user must change width and height
// only while the block is idle, as the block itself does not enforce this.
module argb_to_i420_converter_top #(
  parameter int unsigned MAX_WIDTH = a2i_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [a2i_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [a2i_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  argb_in_if.sink                         in_ch,
  i420_out_if.source                      out_ch
);
  import a2i_pkg::*;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP_W =
    ((COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W) + 1;
  localparam int unsigned HCMP_W = CFG_DATA_W + 1;

  // Per-channel floor average of four pixels.
  function automatic pix_t avg4(pix_t a, pix_t b, pix_t c, pix_t d);
    logic [CH_W+1:0] sr;
    logic [CH_W+1:0] sg;
    logic [CH_W+1:0] sb;
    pix_t            res;
    sr = {2'b00, a.red} + {2'b00, b.red} + {2'b00, c.red} + {2'b00, d.red};
    sg = {2'b00, a.green} + {2'b00, b.green} + {2'b00, c.green} + {2'b00, d.green};
    sb = {2'b00, a.blue} + {2'b00, b.blue} + {2'b00, c.blue} + {2'b00, d.blue};
    res.red   = sr[CH_W+1:2];
    res.green = sg[CH_W+1:2];
    res.blue  = sb[CH_W+1:2];
    return res;
  endfunction

  // Per-channel floor average of two pixels.
  function automatic pix_t avg2(pix_t a, pix_t b);
    logic [CH_W:0] sr;
    logic [CH_W:0] sg;
    logic [CH_W:0] sb;
    pix_t          res;
    sr = {1'b0, a.red} + {1'b0, b.red};
    sg = {1'b0, a.green} + {1'b0, b.green};
    sb = {1'b0, a.blue} + {1'b0, b.blue};
    res.red   = sr[CH_W:1];
    res.green = sg[CH_W:1];
    res.blue  = sb[CH_W:1];
    return res;
  endfunction

  function automatic logic [CH_W-1:0] calc_y(pix_t p);
    logic [17:0] s;
    s = 18'(Y_R) * 18'(p.red) + 18'(Y_G) * 18'(p.green) + 18'(Y_B) * 18'(p.blue)
      + 18'(Y_OFS);
    return s[15:8];
  endfunction

  // The sums stay positive for all inputs; modular arithmetic gives the same bits.
  function automatic logic [CH_W-1:0] calc_u(pix_t p);
    logic [17:0] s;
    s = 18'(C_OFS) + 18'(U_B) * 18'(p.blue) - 18'(U_G) * 18'(p.green)
      - 18'(U_R) * 18'(p.red);
    return s[15:8];
  endfunction

  function automatic logic [CH_W-1:0] calc_v(pix_t p);
    logic [17:0] s;
    s = 18'(C_OFS) + 18'(V_R) * 18'(p.red) - 18'(V_G) * 18'(p.green)
      - 18'(V_B) * 18'(p.blue);
    return s[15:8];
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata;
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves when the output register is free.
  logic out_valid_r;
  logic adv;
  logic acc;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign acc         = in_ch.valid && adv;

  // Position of the next pixel and the previous pixel.
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  pix_t             left_r;
  pix_t             cur;

  assign cur = '{red: in_ch.red, green: in_ch.green, blue: in_ch.blue};

  // Clamp the frame size and find the row and frame edges.
  logic [WCMP_W-1:0] w_raw;
  logic [WCMP_W-1:0] w_eff;
  logic [WCMP_W-1:0] col_inc;
  logic [HCMP_W-1:0] h_raw;
  logic [HCMP_W-1:0] h_eff;
  logic [HCMP_W-1:0] row_inc;
  logic              last_col;
  logic              last_row;
  blk_mode_t         mode;

  always_comb begin
    w_raw = WCMP_W'(width_r);
    if (w_raw == '0) begin
      w_eff = WCMP_W'(1);
    end else if (w_raw > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_raw = HCMP_W'(height_r);
    if (h_raw == '0) begin
      h_eff = HCMP_W'(1);
    end else if (h_raw > HCMP_W'(MAX_HEIGHT)) begin
      h_eff = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
    col_inc  = WCMP_W'(col_r) + WCMP_W'(1);
    row_inc  = HCMP_W'(row_r) + HCMP_W'(1);
    last_col = (col_inc >= w_eff);
    last_row = (row_inc >= h_eff);
  end

  // Choose how the chroma block of this pixel is formed.
  always_comb begin
    mode = BLK_NONE;
    if (row_r[0]) begin
      if (col_r[0]) begin
        mode = BLK_AVG4;
      end else if (last_col) begin
        mode = BLK_VERT;
      end
    end else if (last_row) begin
      if (col_r[0]) begin
        mode = BLK_HORZ;
      end else if (last_col) begin
        mode = BLK_PASS;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (acc) begin
      left_r <= cur;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : ROW_W'(row_inc);
      end else begin
        col_r <= COL_W'(col_inc);
      end
    end
  end

  // Row buffer: even rows write their pixels, odd rows read the one above.
  pix_t row_mem [MAX_WIDTH];
  pix_t rd_data_r;

  always_ff @(posedge clk) begin
    if (acc && !row_r[0]) begin
      row_mem[col_r] <= cur;
    end
    if (acc && row_r[0]) begin
      rd_data_r <= row_mem[col_r];
    end
  end

  // Stage 1: pixel, its left neighbor and the block mode.
  logic      s1_valid_r;
  pix_t      s1_cur_r;
  pix_t      s1_left_r;
  blk_mode_t s1_mode_r;
  logic      s1_fend_r;
  pix_t      upper_prev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_cur_r  <= cur;
      s1_left_r <= left_r;
      s1_mode_r <= mode;
      s1_fend_r <= last_col && last_row;
    end
    // The stored pixel above the previous column.
    if (adv && s1_valid_r) begin
      upper_prev_r <= rd_data_r;
    end
  end

  // Form the block average that feeds chroma.
  pix_t blk;
  logic have;

  always_comb begin
    blk  = s1_cur_r;
    have = 1'b1;
    unique case (s1_mode_r)
      BLK_AVG4: blk = avg4(upper_prev_r, rd_data_r, s1_left_r, s1_cur_r);
      BLK_VERT: blk = avg2(rd_data_r, s1_cur_r);
      BLK_HORZ: blk = avg2(s1_left_r, s1_cur_r);
      BLK_PASS: blk = s1_cur_r;
      default:  have = 1'b0;
    endcase
  end

  // Stage 2: luma and the block that feeds chroma.
  logic            s2_valid_r;
  logic [CH_W-1:0] s2_luma_r;
  pix_t            s2_blk_r;
  logic            s2_have_r;
  logic            s2_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_luma_r <= calc_y(s1_cur_r);
      s2_blk_r  <= blk;
      s2_have_r <= have;
      s2_fend_r <= s1_fend_r;
    end
  end

  // Output register with chroma.
  logic [CH_W-1:0] out_luma_r;
  logic            out_cvalid_r;
  logic [CH_W-1:0] out_cb_r;
  logic [CH_W-1:0] out_cr_r;
  logic            out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      out_luma_r   <= s2_luma_r;
      out_cvalid_r <= s2_have_r;
      out_cb_r     <= s2_have_r ? calc_u(s2_blk_r) : '0;
      out_cr_r     <= s2_have_r ? calc_v(s2_blk_r) : '0;
      out_fend_r   <= s2_fend_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.luma         = out_luma_r;
  assign out_ch.chroma_valid = out_cvalid_r;
  assign out_ch.chroma_u     = out_cb_r;
  assign out_ch.chroma_v     = out_cr_r;
  assign out_ch.frame_end    = out_fend_r;

endmodule

/* src/a2i_checker.sv */
`include "assert_macros.svh"

module a2i_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [a2i_pkg::CH_W-1:0]    luma,
  input logic                        chroma_valid,
  input logic [a2i_pkg::CH_W-1:0]    chroma_u,
  input logic [a2i_pkg::CH_W-1:0]    chroma_v
);
  import a2i_pkg::*;

  logic chroma_zero;
  logic chroma_in_range;

  assign chroma_zero     = (chroma_u == '0) && (chroma_v == '0);
  assign chroma_in_range = (chroma_u >= 8'd16) && (chroma_u <= 8'd240) &&
                           (chroma_v >= 8'd16) && (chroma_v <= 8'd240);

  // A result that is not taken stays offered.
  `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // Input is refused only while a result waits on a stalled output.
  `ASSERT_IMP(a_ready_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

  // Luma stays in the limited range.
  `ASSERT_IMP(a_luma_range, clk, rst_n, out_valid, luma >= 8'd16 && luma <= 8'd235)

  // Without a chroma sample both chroma fields are zero.
  `ASSERT_IMP(a_chroma_zero, clk, rst_n, out_valid && !chroma_valid, chroma_zero)

  // A chroma sample stays in the limited range.
  `ASSERT_IMP(a_chroma_range, clk, rst_n, out_valid && chroma_valid, chroma_in_range)

endmodule

bind argb_to_i420_converter_top a2i_checker u_a2i_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .luma         (out_ch.luma),
  .chroma_valid (out_ch.chroma_valid),
  .chroma_u     (out_ch.chroma_u),
  .chroma_v     (out_ch.chroma_v)
);

/* tb/argb_to_i420_converter_checker.sv */
// Watches the pixel and result channels, predicts every result and compares it.
module argb_to_i420_converter_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [a2i_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [a2i_pkg::CFG_DATA_W-1:0] cfg_wdata,
  argb_in_if                             in_mon,
  i420_out_if                            out_mon,
  output int                             mismatch_count,
  output int                             results_pending,
  output int                             chroma_seen
);
  import a2i_pkg::*;

  localparam int unsigned ROW_DEPTH = 4096;
  localparam int unsigned HEIGHT_CAP = 4096;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } yuv_result_t;

  // Shadow copy of the converter state.
  pix_t            row_above [ROW_DEPTH];
  pix_t            prev_px;
  int unsigned     cur_col;
  int unsigned     cur_row;
  logic [12:0]     width_reg;
  logic [12:0]     height_reg;
  yuv_result_t     expected_results [$];
  yuv_result_t     oldest;
  pix_t            seen_px;

  function automatic logic [7:0] luma_of(input pix_t p);
    int acc;
    acc = 66 * int'(p.red) + 129 * int'(p.green) + 25 * int'(p.blue) + 'h1080;
    return acc[15:8];
  endfunction

  function automatic logic [7:0] u_of(input pix_t p);
    int acc;
    acc = 112 * int'(p.blue) - 74 * int'(p.green) - 38 * int'(p.red) + 'h8080;
    return acc[15:8];
  endfunction

  function automatic logic [7:0] v_of(input pix_t p);
    int acc;
    acc = 112 * int'(p.red) - 94 * int'(p.green) - 18 * int'(p.blue) + 'h8080;
    return acc[15:8];
  endfunction

  // Per-channel floor averages of four and of two pixels.
  function automatic pix_t mean4(input pix_t a, input pix_t b, input pix_t c, input pix_t d);
    pix_t m;
    int   s;
    s = int'(a.red) + int'(b.red) + int'(c.red) + int'(d.red);
    m.red = s[9:2];
    s = int'(a.green) + int'(b.green) + int'(c.green) + int'(d.green);
    m.green = s[9:2];
    s = int'(a.blue) + int'(b.blue) + int'(c.blue) + int'(d.blue);
    m.blue = s[9:2];
    return m;
  endfunction

  function automatic pix_t mean2(input pix_t a, input pix_t b);
    pix_t m;
    int   s;
    s = int'(a.red) + int'(b.red);
    m.red = s[8:1];
    s = int'(a.green) + int'(b.green);
    m.green = s[8:1];
    s = int'(a.blue) + int'(b.blue);
    m.blue = s[8:1];
    return m;
  endfunction

  // Converts one pixel and advances the raster position.
  function automatic yuv_result_t convert_pixel(input pix_t px);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int unsigned row;
    logic        last_col;
    logic        last_row;
    logic        have;
    pix_t        blk;
    yuv_result_t res;
    w = 32'(width_reg);
    h = 32'(height_reg);
    if (w < 1) w = 1;
    if (w > ROW_DEPTH) w = ROW_DEPTH;
    if (h < 1) h = 1;
    if (h > HEIGHT_CAP) h = HEIGHT_CAP;
    col = cur_col;
    row = cur_row;
    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    have = 1'b0;
    blk = '0;

    // Odd rows close the 2x2 blocks; even rows fill the row buffer and, on a final even row, form horizontal pairs.
    if (row[0]) begin
      if (col[0]) begin
        blk = mean4(row_above[col - 1], row_above[col], prev_px, px);
        have = 1'b1;
      end else if (last_col) begin
        blk = mean2(row_above[col], px);
        have = 1'b1;
      end
    end else begin
      row_above[col] = px;
      if (last_row) begin
        if (col[0]) begin
          blk = mean2(prev_px, px);
          have = 1'b1;
        end else if (last_col) begin
          blk = px;
          have = 1'b1;
        end
      end
    end

    res.luma = luma_of(px);
    res.chroma_valid = have;
    res.chroma_u = have ? u_of(blk) : 8'd0;
    res.chroma_v = have ? v_of(blk) : 8'd0;
    res.frame_end = last_col && last_row;

    prev_px = px;
    if (last_col) begin
      cur_col = 0;
      cur_row = last_row ? 0 : row + 1;
    end else begin
      cur_col = col + 1;
    end
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Results are compared before the new prediction is queued, so a result
  // can never be matched against the pixel of the same cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg = 13'd640;
      height_reg = 13'd480;
      prev_px = '0;
      cur_col = 0;
      cur_row = 0;
      expected_results.delete();
      mismatch_count = 0;
      chroma_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_IMAGE_WIDTH:  width_reg = cfg_wdata;
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual luma %0d", $time,
                   out_mon.luma);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("luma", oldest.luma, out_mon.luma);
          check_field("chroma_valid", 8'(oldest.chroma_valid), 8'(out_mon.chroma_valid));
          check_field("chroma_u", oldest.chroma_u, out_mon.chroma_u);
          check_field("chroma_v", oldest.chroma_v, out_mon.chroma_v);
          check_field("frame_end", 8'(oldest.frame_end), 8'(out_mon.frame_end));
          if (oldest.chroma_valid) chroma_seen++;
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        seen_px = {in_mon.red, in_mon.green, in_mon.blue};
        expected_results.push_back(convert_pixel(seen_px));
      end
    end
    results_pending = expected_results.size();
  end

endmodule

/* tb/argb_to_i420_converter_top_tb.sv */
// Drives pixel frames of many sizes into the converter and gives the verdict.
module argb_to_i420_converter_top_tb;
  import a2i_pkg::*;

  localparam int DIM_CAP      = 4096;
  localparam int RANDOM_ITEMS = 900;
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  argb_in_if  pixel_ch ();
  i420_out_if yuv_ch ();

  int mismatch_count;
  int results_pending;
  int chroma_seen;
  int src_idle_pct;
  int snk_idle_pct;
  int sizes_run = 0;
  int in_transfers = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  argb_to_i420_converter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (pixel_ch),
    .out_ch    (yuv_ch)
  );

  argb_to_i420_converter_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_wdata       (cfg_wdata),
    .in_mon          (pixel_ch),
    .out_mon         (yuv_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending),
    .chroma_seen     (chroma_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random back-pressure, plus one long hold-off that lets the
  // converter fill up and stall its pixel input.
  initial begin
    yuv_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        yuv_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        yuv_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && in_transfers >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        yuv_ch.ready <= 1'b0;
      end else begin
        yuv_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Transfer counting and the watchdog on cycles without any transfer.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (pixel_ch.valid && pixel_ch.ready) in_transfers <= in_transfers + 1;
        if ((pixel_ch.valid && pixel_ch.ready) || (yuv_ch.valid && yuv_ch.ready)) begin
          quiet_cycles <= 0;
        end else begin
          quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles.", quiet_cycles);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Channel values lean toward the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    p.red = pick_byte();
    p.green = pick_byte();
    p.blue = pick_byte();
    return p;
  endfunction

  function automatic int clamp_dim(input int v);
    if (v < 1) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return v;
  endfunction

  // Offers one pixel after an optional random gap and returns on its transfer.
  task automatic send_pixel(input pix_t px);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red <= px.red;
    pixel_ch.green <= px.green;
    pixel_ch.blue <= px.blue;
    do @(posedge clk); while (!pixel_ch.ready);
  endtask

  // Stops offering pixels and waits until every predicted result has come.
  task automatic wait_idle();
    pixel_ch.valid <= 1'b0;
    do @(negedge clk); while (results_pending != 0);
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    wait_idle();
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
  endtask

  // Both registers are rewritten once the converter has gone quiet.
  task automatic set_frame_size(input int w_cfg, input int h_cfg);
    wait_idle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= REG_IMAGE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(w_cfg);
    @(posedge clk);
    cfg_idx <= REG_IMAGE_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(h_cfg);
    @(posedge clk);
    cfg_we <= 1'b0;
    sizes_run++;
  endtask

  task automatic run_frames(input int w_cfg, input int h_cfg, input int frames);
    set_frame_size(w_cfg, h_cfg);
    repeat (frames * clamp_dim(w_cfg) * clamp_dim(h_cfg)) send_pixel(random_pixel());
  endtask

  // Stimulus: directed frames first, then random frame sizes, then the
  // register extremes; the random sizes run under three idling patterns.
  initial begin
    logic [23:0] corner_px [9];
    int random_items;
    int regime;
    int last_regime;
    int w;
    int h;
    int frames;

    corner_px = '{24'h000000, 24'hFFFFFF, 24'hFF0000,
                  24'h00FF00, 24'h0000FF, 24'hFFFF00,
                  24'h00FFFF, 24'hFF00FF, 24'h808080};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_IMAGE_WIDTH;
    cfg_wdata <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.red <= '0;
    pixel_ch.green <= '0;
    pixel_ch.blue <= '0;
    src_idle_pct = 6;
    snk_idle_pct = 57;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame of corner colors: a full block, the vertical pair of an odd
    // width, a horizontal pair of an odd last row and its lone final pixel.
    set_frame_size(3, 3);
    foreach (corner_px[i]) send_pixel(pix_t'(corner_px[i]));

    // A zero width acts as one column; a zero height as one row.
    run_frames(0, 2, 1);
    run_frames(3, 0, 1);

    // Shrink the width in the middle of an odd row, then the height on the
    // row that follows, so both end early.
    set_frame_size(4, 3);
    repeat (6) send_pixel(random_pixel());
    set_frame_size(2, 3);
    send_pixel(random_pixel());
    set_frame_size(2, 2);
    repeat (2) send_pixel(random_pixel());

    // Random frame sizes, mostly small, under three idling patterns.
    random_items = 0;
    last_regime = 0;
    while (random_items < RANDOM_ITEMS) begin
      regime = random_items * 3 / RANDOM_ITEMS;
      if (regime != last_regime) begin
        if (regime == 1) set_idling(57, 6);
        else set_idling(0, 0);
        last_regime = regime;
      end
      if ($urandom_range(0, 4) == 0) begin
        w = $urandom_range(13, 64);
        h = $urandom_range(1, 3);
        frames = 1;
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
        frames = $urandom_range(1, 2);
      end
      run_frames(w, h, frames);
      random_items += frames * w * h;
    end

    // All-ones register values clamp to the largest frame dimensions; each
    // such frame is cut short by a smaller size after a stretch of pixels.
    set_frame_size(8191, 2);
    repeat (40) send_pixel(random_pixel());
    set_frame_size(2, 2);
    repeat (3) send_pixel(random_pixel());
    set_frame_size(2, 8191);
    repeat (8) send_pixel(random_pixel());
    set_frame_size(2, 2);
    repeat (2) send_pixel(random_pixel());

    wait_idle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d pixels over %0d frame-size settings; %0d results carried chroma.",
             in_transfers, sizes_run, chroma_seen);
    $display("Covered odd sizes, clamped registers, mid-frame resizing and a long stall.");
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* argb_to_i420_converter_top.f */
+incdir+src
src/a2i_pkg.sv
src/a2i_stream_if.sv
src/argb_to_i420_converter_top.sv
src/a2i_checker.sv
tb/argb_to_i420_converter_checker.sv
tb/argb_to_i420_converter_top_tb.sv
